### design/fto_pkg.sv
// shared types and constants for the two-times fir oversampler
package fto_pkg;

  localparam int MaxTaps   = 128;
  localparam int Channels  = 4;
  localparam int TapW      = $clog2(MaxTaps);
  localparam int ChW       = 2;
  localparam int AddrW     = ChW + TapW;
  localparam int DataW     = 24;
  localparam int AccW      = 64;
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);

  typedef enum logic [1:0] {
    CMD_LOAD_UP   = 2'd0,
    CMD_LOAD_DOWN = 2'd1,
    CMD_UPSAMPLE  = 2'd2,
    CMD_DOWNSAMPLE = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_TAP_COUNT = 1'b0,
    REG_OS_ENABLE = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    JOB_PASS = 2'd0,
    JOB_UP   = 2'd1,
    JOB_DOWN = 2'd2
  } job_kind_t;

  // one classified job handed from front to back
  typedef struct packed {
    job_kind_t               kind;
    logic [ChW-1:0]          channel;
    logic signed [DataW-1:0] value;
  } job_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_OUT
  } back_state_t;

  function automatic logic signed [DataW-1:0] round_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] x;
    logic signed [AccW-1:0] q;
    begin
      x = acc + (AccW'(1) <<< 21);
      q = x >>> 22;
      if (q > AccW'(8388607)) begin
        round_sat = 24'sh7fffff;
      end else if (q < -AccW'(8388608)) begin
        round_sat = 24'sh800000;
      end else begin
        round_sat = q[DataW-1:0];
      end
    end
  endfunction

endpackage

### design/fto_front.sv
// front: accepts items, loads coefficients, queues sample jobs
module fto_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [1:0]                    in_channel,
  input  logic [6:0]                    in_tap_index,
  input  logic signed [23:0]            in_value,
  input  logic                          os_enable,
  input  logic                          back_busy,
  output logic                          coef_we,
  output logic                          coef_sel_down,
  output logic [fto_pkg::TapW-1:0]      coef_addr,
  output logic signed [23:0]            coef_data,
  output logic                          job_valid,
  input  logic                          job_pop,
  output fto_pkg::job_t                 job
);
  import fto_pkg::*;

  job_t               q_r [QDepth];
  logic [QPtrW-1:0]   wp_r, rp_r;
  logic [QPtrW:0]     cnt_r;
  logic               acc_item, push, full, is_load;
  cmd_t               cmd;
  job_t               nj;

  assign cmd      = cmd_t'(in_cmd);
  assign full     = (cnt_r == (QPtrW+1)'(QDepth));
  assign is_load  = (cmd == CMD_LOAD_UP || cmd == CMD_LOAD_DOWN);
  // a load waits until every earlier sample request has been filtered
  assign in_stall = full || (is_load && (job_valid || back_busy));
  assign acc_item = in_valid && !in_stall;
  assign push     = acc_item && (cmd == CMD_UPSAMPLE || cmd == CMD_DOWNSAMPLE)
                    && (32'(in_channel) < Channels);

  assign coef_we       = acc_item && is_load && (32'(in_tap_index) < MaxTaps);
  assign coef_sel_down = (cmd == CMD_LOAD_DOWN);
  assign coef_addr     = in_tap_index[TapW-1:0];
  assign coef_data     = in_value;

  always_comb begin
    nj.channel = in_channel;
    nj.value   = in_value;
    if (!os_enable) begin
      nj.kind = JOB_PASS;
    end else if (cmd == CMD_UPSAMPLE) begin
      nj.kind = JOB_UP;
    end else begin
      nj.kind = JOB_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= nj;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (job_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(job_pop);
    end
  end

  assign job_valid = (cnt_r != '0);
  assign job       = q_r[rp_r];
endmodule

### design/fto_back.sv
// back: ring write, shared multiply-accumulate, rounding and result register
module fto_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [7:0]               tap_count,
  input  logic                     coef_we,
  input  logic                     coef_sel_down,
  input  logic [fto_pkg::TapW-1:0] coef_addr,
  input  logic signed [23:0]       coef_data,
  input  logic                     job_valid,
  output logic                     job_pop,
  input  fto_pkg::job_t            job,
  output logic                     back_busy,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [23:0]       out_sample,
  output logic [1:0]               out_channel,
  output logic                     out_last
);
  import fto_pkg::*;

  logic signed [DataW-1:0] up_coef [MaxTaps];
  logic signed [DataW-1:0] dn_coef [MaxTaps];
  logic signed [DataW-1:0] up_ring [Channels*MaxTaps];
  logic signed [DataW-1:0] dn_ring [Channels*MaxTaps];

  logic [AddrW-1:0] clr_r;
  logic [TapW-1:0]  up_pos_r [Channels];
  logic [TapW-1:0]  dn_pos_r [Channels];
  logic [Channels-1:0] phase_r;

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic        second_r;
  logic [TapW:0]   i_r;
  logic [TapW-1:0] r_r, w_slot;
  logic [TapW:0]   n;
  logic signed [AccW-1:0] acc_r;
  logic signed [DataW-1:0] smp_rd_r, cf_rd_r;
  logic        rd_ok_r, prod_ok_r;
  logic signed [2*DataW-1:0] prod_r;
  logic signed [DataW-1:0] res_r;
  logic        out_valid_r;
  logic        is_down;
  logic [TapW-1:0] pos_cur;
  logic [AddrW-1:0] ring_addr;
  logic signed [DataW-1:0] wr_smp;

  always_comb begin
    if (tap_count == 8'd0) n = (TapW+1)'(1);
    else if (32'(tap_count) > MaxTaps) n = (TapW+1)'(MaxTaps);
    else n = tap_count[TapW:0];
  end

  assign is_down = (job_r.kind == JOB_DOWN);
  assign pos_cur = is_down ? dn_pos_r[job_r.channel] : up_pos_r[job_r.channel];
  assign wr_smp  = second_r ? '0 : job_r.value;

  // write slot: a stale position restarts at zero
  assign w_slot  = ((TapW+1)'(pos_cur) >= n) ? '0 : pos_cur;

  always_ff @(posedge clk) begin
    if (coef_we && !coef_sel_down) up_coef[coef_addr] <= coef_data;
    if (coef_we && coef_sel_down) dn_coef[coef_addr] <= coef_data;
  end

  assign ring_addr = {job_r.channel, (state_r == ST_WRITE) ? w_slot : r_r};

  // ring memories: zeroed by a pass after reset, then written in the write state and read every cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      up_ring[clr_r] <= '0;
      dn_ring[clr_r] <= '0;
    end else if (state_r == ST_WRITE) begin
      if (is_down) dn_ring[ring_addr] <= wr_smp;
      else up_ring[ring_addr] <= wr_smp;
    end
    smp_rd_r <= is_down ? dn_ring[ring_addr] : up_ring[ring_addr];
    cf_rd_r  <= is_down ? dn_coef[i_r[TapW-1:0]] : up_coef[i_r[TapW-1:0]];
    prod_r   <= smp_rd_r * cf_rd_r;
  end

  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    unique case (state_r)
      ST_CLEAR: if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          state_nxt = (job.kind == JOB_PASS) ? ST_OUT : ST_WRITE;
        end
      end
      ST_WRITE: state_nxt = ST_MAC;
      ST_MAC:   if (i_r == n - 1'b1) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!rd_ok_r && !prod_ok_r) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = (is_down && phase_r[job_r.channel]) ? ST_IDLE : ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          if (job_r.kind == JOB_UP && !second_r) state_nxt = ST_WRITE;
          else state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      rd_ok_r     <= 1'b0;
      prod_ok_r   <= 1'b0;
      for (int c = 0; c < Channels; c++) begin
        up_pos_r[c] <= '0;
        dn_pos_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      rd_ok_r   <= (state_r == ST_MAC);
      prod_ok_r <= rd_ok_r;
      unique case (state_r)
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_IDLE: begin
          if (job_valid) begin
            job_r    <= job;
            second_r <= 1'b0;
          end
        end
        ST_WRITE: begin
          if ((TapW+1)'(w_slot) + 1'b1 >= n) begin
            if (is_down) dn_pos_r[job_r.channel] <= '0;
            else up_pos_r[job_r.channel] <= '0;
          end else begin
            if (is_down) dn_pos_r[job_r.channel] <= w_slot + 1'b1;
            else up_pos_r[job_r.channel] <= w_slot + 1'b1;
          end
          r_r   <= w_slot;
          i_r   <= '0;
          acc_r <= '0;
        end
        ST_MAC: begin
          i_r <= i_r + 1'b1;
          r_r <= (r_r == '0) ? TapW'(n - 1'b1) : r_r - 1'b1;
        end
        ST_ROUND: begin
          res_r <= round_sat(acc_r);
          if (is_down) phase_r[job_r.channel] <= ~phase_r[job_r.channel];
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_sample  <= (job_r.kind == JOB_PASS) ? job_r.value : res_r;
            out_channel <= job_r.channel;
            out_last    <= !(job_r.kind == JOB_UP && !second_r);
            second_r    <= 1'b1;
          end
        end
        default: ;
      endcase
      if (prod_ok_r) acc_r <= acc_r + AccW'(prod_r);
    end
  end

  assign back_busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
endmodule

### design/fir_two_times_oversampler.sv
// top level of the two-times fir oversampler
// After reset a clearing pass zeroes all 512 delay-line entries before the first request
// is filtered. Each sample request is filtered by one shared multiply-accumulate that walks the
// effective tap count n one tap a cycle: an upsample takes two passes, a downsample one, and a
// disabled pass-through none. A four-entry queue sits between intake and filter, so new sample
// requests are taken while a filter pass runs until the queue is full; a coefficient load is held
// off until the queue is empty and the filter is idle, and is then written as it is accepted. The
// result register lets the next pass start while a result waits.
module fir_two_times_oversampler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [1:0]         in_channel,
  input  logic [6:0]         in_tap_index,
  input  logic signed [23:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_sample,
  output logic [1:0]         out_channel,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import fto_pkg::*;

  logic [7:0]       tap_count_r;
  logic             os_enable_r;
  logic             coef_we, coef_sel_down, job_valid, job_pop, back_busy;
  logic [TapW-1:0]  coef_addr;
  logic signed [23:0] coef_data;
  job_t             job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= 8'd117;
      os_enable_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TAP_COUNT: tap_count_r <= cfg_data;
        REG_OS_ENABLE: os_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fto_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_channel, .in_tap_index, .in_value,
    .os_enable(os_enable_r), .back_busy, .coef_we, .coef_sel_down, .coef_addr, .coef_data,
    .job_valid, .job_pop, .job
  );

  fto_back u_back (
    .clk, .rst_n, .tap_count(tap_count_r), .coef_we, .coef_sel_down, .coef_addr,
    .coef_data, .job_valid, .job_pop, .job, .back_busy, .out_valid, .out_stall, .out_sample,
    .out_channel, .out_last
  );
endmodule
